@@ rtl/mpqu_pkg.sv @@
// ---------------------------------------------------------------------------
// mpqu_pkg: shared types and constants for the unsorted min-priority queue
// Transaction codes, controller states and controller/datapath bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package mpqu_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int TAG_W        = 16;
	localparam int PRIO_W       = 16;
	localparam int MODE_W       = 3;
	localparam int STATUS_W     = 2;
	localparam int OCC_W        = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT  = 3'd0,
		MODE_EXTRACT = 3'd1,
		MODE_PEEK    = 3'd2,
		MODE_UPGRADE = 3'd3,
		MODE_CLEAR   = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_NOMATCH = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SCAN_DRAIN,
		S_SCAN_DONE,
		S_SHIFT,
		S_SHIFT_DRAIN,
		S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    accept;
		logic    insert_wr;
		logic    upg_wr;
		logic    fill_inc;
		logic    fill_dec;
		logic    fill_clr;
		logic    scan_start;
		logic    scan_issue;
		logic    shift_start;
		logic    shift_issue;
		logic    set_result;
		status_t res_status;
		logic    res_best;
		logic    load_result;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              empty;
		logic              full;
		logic              last_issue;
		logic              found;
		logic              shift_none;
		logic              out_free;
	} stat_t;

endpackage

`default_nettype wire

@@ rtl/mpqu_req_if.sv @@
// ---------------------------------------------------------------------------
// mpqu_req_if: request channel
// valid/ready channel carrying one queue request per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface mpqu_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [mpqu_pkg::MODE_W-1:0]          mode;
	logic [mpqu_pkg::TAG_W-1:0]           tag;
	logic signed [mpqu_pkg::PRIO_W-1:0]   priority_req;

	modport source (output valid, output mode, output tag, output priority_req, input ready);
	modport sink   (input valid, input mode, input tag, input priority_req, output ready);
endinterface

`default_nettype wire

@@ rtl/mpqu_rsp_if.sv @@
// ---------------------------------------------------------------------------
// mpqu_rsp_if: response channel
// valid/ready channel carrying one result per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface mpqu_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [mpqu_pkg::TAG_W-1:0]           out_tag;
	logic signed [mpqu_pkg::PRIO_W-1:0]   out_priority;
	logic [mpqu_pkg::STATUS_W-1:0]        status;
	logic [mpqu_pkg::OCC_W-1:0]           occupancy;

	modport source (output valid, output out_tag, output out_priority, output status,
		output occupancy, input ready);
	modport sink   (input valid, input out_tag, input out_priority, input status,
		input occupancy, output ready);
endinterface

`default_nettype wire

@@ rtl/mpqu_ram.sv @@
// ---------------------------------------------------------------------------
// mpqu_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mpqu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/mpqu_datapath.sv @@
// ---------------------------------------------------------------------------
// mpqu_datapath: entry store, scan/shift pipeline and result register
// Holds the fill count, the minimum/match tracker and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mpqu_datapath #(
	parameter int CAPACITY = mpqu_pkg::CAPACITY_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mpqu_pkg::cmd_t                       cmd,
	output mpqu_pkg::stat_t                           stat,
	input  wire logic [mpqu_pkg::MODE_W-1:0]          in_mode,
	input  wire logic [mpqu_pkg::TAG_W-1:0]           in_tag,
	input  wire logic signed [mpqu_pkg::PRIO_W-1:0]   in_priority,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [mpqu_pkg::TAG_W-1:0]                out_tag,
	output logic signed [mpqu_pkg::PRIO_W-1:0]        out_priority,
	output logic [mpqu_pkg::STATUS_W-1:0]             out_status,
	output logic [mpqu_pkg::OCC_W-1:0]                out_occupancy
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int ENT_W = mpqu_pkg::TAG_W + mpqu_pkg::PRIO_W;

	// latched request
	logic [mpqu_pkg::MODE_W-1:0]        mode_q;
	logic [mpqu_pkg::TAG_W-1:0]         tag_q;
	logic signed [mpqu_pkg::PRIO_W-1:0] prio_q;

	logic [CW-1:0] fill_q;
	logic [AW-1:0] idx_q;

	// read pipeline
	logic          rd_vld_s1;
	logic          rd_shift_s1;
	logic [AW-1:0] rd_idx_s1;

	// best candidate
	logic                               best_found_q;
	logic [AW-1:0]                      best_idx_q;
	logic signed [mpqu_pkg::PRIO_W-1:0] best_prio_q;
	logic [mpqu_pkg::TAG_W-1:0]         best_tag_q;

	mpqu_pkg::status_t res_status_q;
	logic              res_best_q;

	logic                               we;
	logic [AW-1:0]                      waddr;
	logic [ENT_W-1:0]                   wdata;
	logic [ENT_W-1:0]                   rdata;
	logic                               re;
	logic [mpqu_pkg::TAG_W-1:0]         r_tag;
	logic signed [mpqu_pkg::PRIO_W-1:0] r_prio;
	logic                               cand;
	logic                               take;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= in_mode;
			tag_q  <= in_tag;
			prio_q <= in_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_clr) begin
			fill_q <= '0;
		end else if (cmd.fill_inc) begin
			fill_q <= fill_q + CW'(1);
		end else if (cmd.fill_dec) begin
			fill_q <= fill_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.shift_start) begin
			idx_q <= best_idx_q + AW'(1);
		end else if (cmd.scan_issue || cmd.shift_issue) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	assign re = cmd.scan_issue | cmd.shift_issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= re;
		end
	end

	always_ff @(posedge clk) begin
		rd_shift_s1 <= cmd.shift_issue;
		rd_idx_s1   <= idx_q;
	end

	assign r_tag  = rdata[ENT_W-1:mpqu_pkg::PRIO_W];
	assign r_prio = signed'(rdata[mpqu_pkg::PRIO_W-1:0]);

	// upgrade only considers same tag with a strictly larger priority
	assign cand = (mode_q == mpqu_pkg::MODE_UPGRADE) ? ((r_tag == tag_q) && (r_prio > prio_q))
		: 1'b1;
	assign take = cand && (!best_found_q || (r_prio < best_prio_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			best_found_q <= 1'b0;
		end else if (rd_vld_s1 && !rd_shift_s1 && take) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !rd_shift_s1 && take) begin
			best_idx_q  <= rd_idx_s1;
			best_prio_q <= r_prio;
			best_tag_q  <= r_tag;
		end
	end

	// write port: insert at the tail, upgrade in place, or shift down by one
	always_comb begin
		we    = 1'b0;
		waddr = best_idx_q;
		wdata = {tag_q, prio_q};
		if (cmd.insert_wr) begin
			we    = 1'b1;
			waddr = fill_q[AW-1:0];
		end else if (cmd.upg_wr) begin
			we    = 1'b1;
		end else if (rd_vld_s1 && rd_shift_s1) begin
			we    = 1'b1;
			waddr = rd_idx_s1 - AW'(1);
			wdata = rdata;
		end
	end

	mpqu_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.set_result) begin
			res_status_q <= cmd.res_status;
			res_best_q   <= cmd.res_best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_tag       <= res_best_q ? best_tag_q : '0;
			out_priority  <= res_best_q ? best_prio_q : '0;
			out_status    <= res_status_q;
			out_occupancy <= mpqu_pkg::OCC_W'(fill_q);
		end
	end

	always_comb begin
		stat.mode       = mode_q;
		stat.empty      = (fill_q == '0);
		stat.full       = (fill_q == CW'(CAPACITY));
		stat.last_issue = ((CW'(idx_q) + CW'(1)) == fill_q);
		stat.found      = best_found_q;
		stat.shift_none = ((CW'(best_idx_q) + CW'(1)) == fill_q);
		stat.out_free   = !out_valid || out_ready;
	end

endmodule

`default_nettype wire

@@ rtl/mpqu_ctrl.sv @@
// ---------------------------------------------------------------------------
// mpqu_ctrl: request sequencer
// Decodes the latched request and steps scan, shift and response phases.
// ---------------------------------------------------------------------------
`default_nettype none

module mpqu_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire mpqu_pkg::stat_t stat,
	output mpqu_pkg::cmd_t       cmd
);

	mpqu_pkg::state_t state_q;
	mpqu_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpqu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mpqu_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = mpqu_pkg::S_EXEC;
				end
			end
			mpqu_pkg::S_EXEC: begin
				cmd.set_result = 1'b1;
				cmd.res_status = mpqu_pkg::ST_OK;
				state_d        = mpqu_pkg::S_RESP;
				case (stat.mode)
					mpqu_pkg::MODE_INSERT: begin
						if (stat.full) begin
							cmd.res_status = mpqu_pkg::ST_FULL;
						end else begin
							cmd.insert_wr = 1'b1;
							cmd.fill_inc  = 1'b1;
						end
					end
					mpqu_pkg::MODE_EXTRACT, mpqu_pkg::MODE_PEEK: begin
						if (stat.empty) begin
							cmd.res_status = mpqu_pkg::ST_EMPTY;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = mpqu_pkg::S_SCAN;
						end
					end
					mpqu_pkg::MODE_UPGRADE: begin
						if (stat.empty) begin
							cmd.res_status = mpqu_pkg::ST_NOMATCH;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = mpqu_pkg::S_SCAN;
						end
					end
					mpqu_pkg::MODE_CLEAR: begin
						cmd.fill_clr = 1'b1;
					end
					default: begin
					end
				endcase
			end
			mpqu_pkg::S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.last_issue) begin
					state_d = mpqu_pkg::S_SCAN_DRAIN;
				end
			end
			mpqu_pkg::S_SCAN_DRAIN: begin
				state_d = mpqu_pkg::S_SCAN_DONE;
			end
			mpqu_pkg::S_SCAN_DONE: begin
				cmd.set_result = 1'b1;
				state_d        = mpqu_pkg::S_RESP;
				if (stat.mode == mpqu_pkg::MODE_UPGRADE) begin
					if (stat.found) begin
						cmd.upg_wr     = 1'b1;
						cmd.res_status = mpqu_pkg::ST_OK;
					end else begin
						cmd.res_status = mpqu_pkg::ST_NOMATCH;
					end
				end else begin
					cmd.res_status = mpqu_pkg::ST_OK;
					cmd.res_best   = 1'b1;
					if (stat.mode == mpqu_pkg::MODE_EXTRACT) begin
						if (stat.shift_none) begin
							cmd.fill_dec = 1'b1;
						end else begin
							cmd.shift_start = 1'b1;
							state_d         = mpqu_pkg::S_SHIFT;
						end
					end
				end
			end
			mpqu_pkg::S_SHIFT: begin
				cmd.shift_issue = 1'b1;
				if (stat.last_issue) begin
					state_d = mpqu_pkg::S_SHIFT_DRAIN;
				end
			end
			mpqu_pkg::S_SHIFT_DRAIN: begin
				cmd.fill_dec = 1'b1;
				state_d      = mpqu_pkg::S_RESP;
			end
			mpqu_pkg::S_RESP: begin
				if (stat.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = mpqu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpqu_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/min_priority_queue_unsorted.sv @@
// ---------------------------------------------------------------------------
// min_priority_queue_unsorted: bounded min-priority queue in arrival order
// Insert, extract-min, peek-min, upgrade (decrease-key) and clear; one
// result per request transaction.
// ---------------------------------------------------------------------------
// Entries live in a single-port-write, single-port-read RAM in arrival order,
// so ties on priority resolve to the earliest arrival. One request is worked
// at a time. Insert, clear, unused modes and requests that fail on an empty
// or full queue go from the execute state straight to the response state.
// Peek and upgrade scan all N held entries through the RAM read port. Extract
// scans, then moves every later entry down one slot, one RAM read and one
// write per cycle. The result sits in an output register, so a new request
// is taken while it waits. Entries are never cleared in the RAM; only slots
// below the fill count are read, so no initialization pass is needed after
// reset.
// ---------------------------------------------------------------------------
`default_nettype none

module min_priority_queue_unsorted #(
	parameter int CAPACITY = mpqu_pkg::CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mpqu_req_if.sink   req,
	mpqu_rsp_if.source rsp
);

	mpqu_pkg::cmd_t  cmd;
	mpqu_pkg::stat_t stat;
	logic            in_ready;

	assign req.ready = in_ready;

	// sequencer: accepts a transaction only when idle
	mpqu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// entry RAM, fill count, min/match tracker and result register
	mpqu_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_mode      (req.mode),
		.in_tag       (req.tag),
		.in_priority  (req.priority_req),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_tag      (rsp.out_tag),
		.out_priority (rsp.out_priority),
		.out_status   (rsp.status),
		.out_occupancy(rsp.occupancy)
	);

endmodule

`default_nettype wire
